// ===== hdl/rlpe_pkg.sv =====
// Shared types, constants and helpers for the RGB LED pulse encoder.
`default_nettype none

package rlpe_pkg;

    localparam int TICK_W     = 16;
    localparam int GAP_W      = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int COLOR_W    = 8;
    localparam int PIXEL_W    = 3 * COLOR_W;

    // action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_GAP = 3'd4;

    // reset values: 300/900/600/600 ns and 80 us at 10 ns per tick
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd30;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 16'd90;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd60;
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = 16'd60;
    localparam logic [GAP_W-1:0]  RST_LATCH_GAP = 20'd8000;

    // classified command passed from front to back
    typedef struct packed {
        logic               is_load;
        logic [PIXEL_W-1:0] pixel;   // green, red, blue; MSB first
    } rlpe_cmd_t;

    // one result transaction
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_rejected;
        logic frame_done;
    } rlpe_res_t;

    // a zero length counts as one tick
    function automatic logic [GAP_W-1:0] at_least_one(input logic [GAP_W-1:0] v);
        logic [GAP_W-1:0] r;
        r = (v == '0) ? GAP_W'(1) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_led_pulse_encoder_core.sv =====
// Top level of the RGB LED pulse encoder: front end, command queue, back end.
//
// One-wire LED serializer for a single pixel. Each input transaction is
// either a pixel load (action = 1) or one line tick (action = 0); every
// transaction produces exactly one result transaction giving the line level,
// busy, load-rejected and frame-done flags after it. A load sends green, red,
// blue MSB first (plus trailing zero bits when BITS_PER_PIXEL > 24), each bit
// as a high then a low phase whose tick counts come from the configuration
// registers, then holds the line low for the latch gap. A load while busy is
// dropped and flagged. Throughput is one transaction per clock while out_stall
// is low: the front end classifies the transaction into a two-entry queue and
// the back end retires one queued command per cycle into the result register
// unless a pending result is stalled, so a transaction passes through the queue
// and then the result register before its result sits on the result ports. The
// queue and the result register let input and output stall independently;
// in_stall rises only when the queue is full. Configuration writes take effect
// at the next phase that starts and should be made while the block is idle.
`default_nettype none

module rgb_led_pulse_encoder_core
    import rlpe_pkg::*;
#(
    parameter int BITS_PER_PIXEL = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  action,
    input  wire logic [COLOR_W-1:0]    red,
    input  wire logic [COLOR_W-1:0]    green,
    input  wire logic [COLOR_W-1:0]    blue,

    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       line_level,
    output logic                       busy_res,
    output logic                       load_rejected,
    output logic                       frame_done
);

    rlpe_cmd_t push_data;
    rlpe_cmd_t pop_data;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    rlpe_res_t res;

    rlpe_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    rlpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_data)
    );

    rlpe_back #(
        .BITS_PER_PIXEL (BITS_PER_PIXEL)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    // result fields onto their own ports
    assign line_level    = res.line_level;
    assign busy_res      = res.busy_res;
    assign load_rejected = res.load_rejected;
    assign frame_done    = res.frame_done;

endmodule

`default_nettype wire

// ===== hdl/rlpe_front.sv =====
// Front end: accepts input transactions and classifies them into commands.
`default_nettype none

module rlpe_front
    import rlpe_pkg::*;
(
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [COLOR_W-1:0] red,
    input  wire logic [COLOR_W-1:0] green,
    input  wire logic [COLOR_W-1:0] blue,
    input  wire logic               q_full,
    output logic                    q_push,
    output rlpe_cmd_t               q_data
);

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data.is_load = (action == ACT_LOAD);
        // wire order is green, red, blue
        q_data.pixel   = {green, red, blue};
    end

endmodule

`default_nettype wire

// ===== hdl/rlpe_queue.sv =====
// Two-entry command queue between front and back.
`default_nettype none

module rlpe_queue
    import rlpe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  rlpe_cmd_t      push_data,
    output logic           full,
    input  wire logic      pop,
    output logic           pop_valid,
    output rlpe_cmd_t      pop_data
);

    rlpe_cmd_t   mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rlpe_back.sv =====
// Back end: line timing state machine, config registers and result register.
`default_nettype none

module rlpe_back
    import rlpe_pkg::*;
#(
    parameter int BITS_PER_PIXEL = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_valid,
    input  rlpe_cmd_t                  q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output rlpe_res_t                  res
);

    localparam int BL_W = $clog2(BITS_PER_PIXEL + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    logic [TICK_W-1:0]         zero_high_reg;
    logic [TICK_W-1:0]         zero_low_reg;
    logic [TICK_W-1:0]         one_high_reg;
    logic [TICK_W-1:0]         one_low_reg;
    logic [GAP_W-1:0]          latch_gap_reg;

    phase_t                    phase_reg,  phase_next;
    logic [GAP_W-1:0]          count_reg,  count_next;
    logic [BITS_PER_PIXEL-1:0] shift_reg,  shift_next;
    logic [BL_W-1:0]           bits_reg,   bits_next;
    logic                      out_valid_reg;
    rlpe_res_t                 res_reg,    res_next;

    logic [GAP_W-1:0]          count_dec;
    logic [BL_W-1:0]           bits_dec;
    logic                      next_bit;

    assign q_pop     = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        res_next   = '0;
        count_dec  = (count_reg != '0) ? count_reg - GAP_W'(1) : count_reg;
        bits_dec   = (bits_reg != '0) ? bits_reg - BL_W'(1) : bits_reg;
        next_bit   = shift_reg[BITS_PER_PIXEL-2];

        if (q_data.is_load)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res_next.load_rejected = 1'b1;
            end
            else
            begin
                // extra trailing bits go out as zeros
                shift_next = BITS_PER_PIXEL'(q_data.pixel) << (BITS_PER_PIXEL - PIXEL_W);
                bits_next  = BL_W'(BITS_PER_PIXEL);
                phase_next = PH_HIGH;
                count_next = at_least_one(q_data.pixel[PIXEL_W-1] ?
                                          GAP_W'(one_high_reg) : GAP_W'(zero_high_reg));
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            count_next = count_dec;
            if (count_dec == '0)
            begin
                case (phase_reg)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        count_next = at_least_one(shift_reg[BITS_PER_PIXEL-1] ?
                                                  GAP_W'(one_low_reg) : GAP_W'(zero_low_reg));
                    end
                    PH_LOW:
                    begin
                        shift_next = shift_reg << 1;
                        bits_next  = bits_dec;
                        if (bits_dec != '0)
                        begin
                            phase_next = PH_HIGH;
                            count_next = at_least_one(next_bit ?
                                                      GAP_W'(one_high_reg) :
                                                      GAP_W'(zero_high_reg));
                        end
                        else
                        begin
                            phase_next = PH_LATCH;
                            count_next = at_least_one(latch_gap_reg);
                        end
                    end
                    PH_LATCH:
                    begin
                        phase_next          = PH_IDLE;
                        count_next          = '0;
                        res_next.frame_done = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        res_next.line_level = (phase_next == PH_HIGH);
        res_next.busy_res   = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg <= RST_ZERO_HIGH;
            zero_low_reg  <= RST_ZERO_LOW;
            one_high_reg  <= RST_ONE_HIGH;
            one_low_reg   <= RST_ONE_LOW;
            latch_gap_reg <= RST_LATCH_GAP;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            shift_reg     <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ZERO_HIGH: zero_high_reg <= cfg_data[TICK_W-1:0];
                    CFG_ZERO_LOW:  zero_low_reg  <= cfg_data[TICK_W-1:0];
                    CFG_ONE_HIGH:  one_high_reg  <= cfg_data[TICK_W-1:0];
                    CFG_ONE_LOW:   one_low_reg   <= cfg_data[TICK_W-1:0];
                    CFG_LATCH_GAP: latch_gap_reg <= cfg_data[GAP_W-1:0];
                    default:       ;
                endcase
            end

            if (q_pop)
            begin
                phase_reg     <= phase_next;
                count_reg     <= count_next;
                shift_reg     <= shift_next;
                bits_reg      <= bits_next;
                res_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
